>>> src/cihl_pkg.sv
// Shared types and constants for the cartridge image header loader.
package cihl_pkg;

  localparam int unsigned CntW      = 22;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned KindW     = 3;

  localparam logic [CntW-1:0] HeaderLast  = CntW'(15);
  localparam logic [CntW-1:0] TrainerLen  = CntW'(512);
  localparam int unsigned     PrgBankLog2 = 14;  // 16384-byte banks
  localparam int unsigned     ChrBankLog2 = 13;  // 8192-byte banks

  localparam logic [3:0][7:0] MagicBytes = {8'h1A, 8'h53, 8'h45, 8'h4E};

  // Region code, also reported as the result kind.
  typedef enum logic [KindW-1:0] {
    PH_HEADER  = 3'd0,
    PH_TRAINER = 3'd1,
    PH_PRG     = 3'd2,
    PH_CHR     = 3'd3,
    PH_IGNORE  = 3'd4,
    PH_REJECT  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAGIC = 2'd1,
    ERR_NES2  = 2'd2
  } err_e;

  // Bit positions inside the result tdata word.
  localparam int unsigned OffLsb   = 8;
  localparam int unsigned HvBit    = 30;
  localparam int unsigned ErrLsb   = 31;
  localparam int unsigned PrgLsb   = 33;
  localparam int unsigned ChrLsb   = 41;
  localparam int unsigned MirLsb   = 49;
  localparam int unsigned BatBit   = 51;
  localparam int unsigned TrnBit   = 52;
  localparam int unsigned MapLsb   = 53;

endpackage

>>> src/cartridge_image_header_loader.sv
// Cartridge image header loader: parses the image header and tags each byte.
//
// Takes one image byte per request on the slave stream and returns one
// tagged result per byte on the master stream. The first 16 bytes are the
// header (magic check, bank counts, flag bytes); it is judged on its last
// byte, whose result already shows header_valid or the error code. After a
// good header the bytes are tagged as trainer (512 bytes, if flagged),
// program ROM (banks x 16384), character ROM (banks x 8192), then ignored.
// Empty regions are skipped. A bad magic value or the NES 2.0 mark makes
// every later byte come back as rejected until reset; the error is sticky.
// Throughput is one byte per clock unless the sink stalls: the parser state
// updates in a single register stage and the result lands in one output
// register, so input ready only drops while that register holds a result
// the sink is not taking. No memory, so no startup pass after reset.
module cartridge_image_header_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] image_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [29:8] offset, [30] header_valid, [32:31] error_code,
  // [40:33] prg_banks, [48:41] chr_banks, [50:49] mirroring, [51] battery,
  // [52] trainer, [60:53] mapper, [63:61] zero
  output logic [63:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o    // [2:0] kind
);

  localparam int unsigned CntW = cihl_pkg::CntW;

  // parser state
  cihl_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             magic_ok_q, magic_ok_d;
  logic [7:0]       prg_q, prg_d;
  logic [7:0]       chr_q, chr_d;
  logic [7:0]       flags6_q, flags6_d;
  logic [7:0]       flags7_q, flags7_d;
  cihl_pkg::err_e   err_q, err_d;

  // output register
  logic             out_valid_q;
  logic [63:0]      out_data_q, out_data_d;
  logic [2:0]       out_kind_q, out_kind_d;

  logic             accept;
  logic [CntW-1:0]  cnt_inc;
  logic [CntW-1:0]  region_len;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc         = cnt_q + CntW'(1);

  // First non-empty region at or after 'from'.
  function automatic cihl_pkg::phase_e next_region(input cihl_pkg::phase_e from,
                                                   input logic has_trainer,
                                                   input logic [7:0] prg,
                                                   input logic [7:0] chr);
    cihl_pkg::phase_e r;
    if (from <= cihl_pkg::PH_TRAINER && has_trainer) r = cihl_pkg::PH_TRAINER;
    else if (from <= cihl_pkg::PH_PRG && prg != 8'd0) r = cihl_pkg::PH_PRG;
    else if (from <= cihl_pkg::PH_CHR && chr != 8'd0) r = cihl_pkg::PH_CHR;
    else r = cihl_pkg::PH_IGNORE;
    return r;
  endfunction

  always_comb begin
    unique case (phase_q)
      cihl_pkg::PH_TRAINER: region_len = cihl_pkg::TrainerLen;
      cihl_pkg::PH_PRG:     region_len = CntW'(prg_q) << cihl_pkg::PrgBankLog2;
      cihl_pkg::PH_CHR:     region_len = CntW'(chr_q) << cihl_pkg::ChrBankLog2;
      default:              region_len = '0;
    endcase
  end

  // Next parser state for the byte being taken.
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    magic_ok_d = magic_ok_q;
    prg_d      = prg_q;
    chr_d      = chr_q;
    flags6_d   = flags6_q;
    flags7_d   = flags7_q;
    err_d      = err_q;
    unique case (phase_q)
      cihl_pkg::PH_HEADER: begin
        priority if (cnt_q < CntW'(4)) begin
          if (s_axis_tdata_i != cihl_pkg::MagicBytes[cnt_q[1:0]]) magic_ok_d = 1'b0;
        end else if (cnt_q == CntW'(4)) begin
          prg_d = s_axis_tdata_i;
        end else if (cnt_q == CntW'(5)) begin
          chr_d = s_axis_tdata_i;
        end else if (cnt_q == CntW'(6)) begin
          flags6_d = s_axis_tdata_i;
        end else if (cnt_q == CntW'(7)) begin
          flags7_d = s_axis_tdata_i;
        end else begin
        end
        if (cnt_q >= cihl_pkg::HeaderLast) begin
          cnt_d = '0;
          // magic error wins over the NES 2.0 mark
          priority if (!magic_ok_d) begin
            err_d   = cihl_pkg::ERR_MAGIC;
            phase_d = cihl_pkg::PH_REJECT;
          end else if (flags7_d[3:2] == 2'b10) begin
            err_d   = cihl_pkg::ERR_NES2;
            phase_d = cihl_pkg::PH_REJECT;
          end else begin
            phase_d = next_region(cihl_pkg::PH_TRAINER, flags6_d[2], prg_d, chr_d);
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      cihl_pkg::PH_TRAINER, cihl_pkg::PH_PRG, cihl_pkg::PH_CHR: begin
        if (cnt_inc >= region_len) begin
          cnt_d   = '0;
          phase_d = next_region(cihl_pkg::phase_e'(phase_q + 3'd1),
                                flags6_q[2], prg_q, chr_q);
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word, decoded fields taken from the updated state.
  always_comb begin
    logic        hv;
    logic [1:0]  mir;
    logic [21:0] off;
    cihl_pkg::phase_e kind;
    hv  = (err_d == cihl_pkg::ERR_NONE) && (phase_d != cihl_pkg::PH_HEADER);
    mir = {flags6_d[3], flags6_d[0]};
    unique case (phase_q)
      cihl_pkg::PH_HEADER, cihl_pkg::PH_TRAINER,
      cihl_pkg::PH_PRG, cihl_pkg::PH_CHR: begin
        kind = phase_q;
        off  = cnt_q;
      end
      cihl_pkg::PH_IGNORE: begin
        kind = cihl_pkg::PH_IGNORE;
        off  = '0;
      end
      default: begin
        kind = cihl_pkg::PH_REJECT;
        off  = '0;
      end
    endcase
    out_kind_d = kind;
    out_data_d = '0;
    out_data_d[7:0]                       = s_axis_tdata_i;
    out_data_d[cihl_pkg::OffLsb +: 22]    = off;
    out_data_d[cihl_pkg::HvBit]           = hv;
    out_data_d[cihl_pkg::ErrLsb +: 2]     = err_d;
    if (hv) begin
      out_data_d[cihl_pkg::PrgLsb +: 8]   = prg_d;
      out_data_d[cihl_pkg::ChrLsb +: 8]   = chr_d;
      out_data_d[cihl_pkg::MirLsb +: 2]   = mir;
      out_data_d[cihl_pkg::BatBit]        = flags6_d[1];
      out_data_d[cihl_pkg::TrnBit]        = flags6_d[2];
      out_data_d[cihl_pkg::MapLsb +: 8]   = {flags7_d[7:4], flags6_d[7:4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cihl_pkg::PH_HEADER;
      cnt_q      <= '0;
      magic_ok_q <= 1'b1;
      prg_q      <= '0;
      chr_q      <= '0;
      flags6_q   <= '0;
      flags7_q   <= '0;
      err_q      <= cihl_pkg::ERR_NONE;
    end else if (accept) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      magic_ok_q <= magic_ok_d;
      prg_q      <= prg_d;
      chr_q      <= chr_d;
      flags6_q   <= flags6_d;
      flags7_q   <= flags7_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

>>> src/cihl_checker.sv
// Port-level checks for the cartridge image header loader, with bind.
module cihl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a result waiting on a stalled sink holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // input is only held off by a stalled full output register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // valid header and error code exclude each other
  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[cihl_pkg::HvBit] |->
      m_axis_tdata_o[cihl_pkg::ErrLsb +: 2] == cihl_pkg::ERR_NONE)
    else $error("header valid with error set");

  // rejected bytes carry an error and a zero offset
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == cihl_pkg::PH_REJECT |->
      m_axis_tdata_o[cihl_pkg::ErrLsb +: 2] != cihl_pkg::ERR_NONE &&
      m_axis_tdata_o[cihl_pkg::OffLsb +: 22] == 22'd0)
    else $error("rejected byte without error");

endmodule

bind cartridge_image_header_loader cihl_checker u_cihl_checker (.*);

>>> tb/cihl_result_checker.sv
`timescale 1ns / 100ps
// Checker for the cartridge image header loader: predicts each tagged byte and compares results.
module cihl_result_checker
  import cihl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct packed {
    phase_e      kind;
    logic [7:0]  data_byte;
    logic [21:0] offset;
    logic        header_valid;
    err_e        error_code;
    logic [7:0]  prg_banks;
    logic [7:0]  chr_banks;
    logic [1:0]  mirroring;
    logic        battery;
    logic        trainer;
    logic [7:0]  mapper;
  } tagged_byte_t;

  // Parser state as the block should hold it.
  phase_e      region;
  logic [21:0] pos;
  logic        magic_ok;
  logic [7:0]  prg_count;
  logic [7:0]  chr_count;
  logic [7:0]  flags6;
  logic [7:0]  flags7;
  err_e        error_state;

  tagged_byte_t tagged_q[$];
  int mismatches = 0;

  assign mismatches_o = mismatches;

  // First non-empty region at or after the given one.
  function automatic phase_e first_region(phase_e from);
    if (from <= PH_TRAINER && flags6[2]) return PH_TRAINER;
    if (from <= PH_PRG && prg_count != 8'd0) return PH_PRG;
    if (from <= PH_CHR && chr_count != 8'd0) return PH_CHR;
    return PH_IGNORE;
  endfunction

  function automatic tagged_byte_t tag_byte(logic [7:0] b);
    tagged_byte_t r;
    logic [22:0]  span;
    r = '0;
    r.kind = region;
    r.data_byte = b;
    case (region)
      PH_HEADER: begin
        r.offset = pos;
        if (pos < 22'd4) begin
          if (b != MagicBytes[pos[1:0]]) magic_ok = 1'b0;
        end else if (pos == 22'd4) begin
          prg_count = b;
        end else if (pos == 22'd5) begin
          chr_count = b;
        end else if (pos == 22'd6) begin
          flags6 = b;
        end else if (pos == 22'd7) begin
          flags7 = b;
        end
        // Judged on the last header byte; bad magic wins over the NES 2.0 mark.
        if (pos >= HeaderLast) begin
          pos = '0;
          if (!magic_ok) begin
            error_state = ERR_MAGIC;
            region = PH_REJECT;
          end else if (flags7[3:2] == 2'b10) begin
            error_state = ERR_NES2;
            region = PH_REJECT;
          end else begin
            region = first_region(PH_TRAINER);
          end
        end else begin
          pos = pos + 22'd1;
        end
      end
      PH_TRAINER, PH_PRG, PH_CHR: begin
        r.offset = pos;
        if (region == PH_TRAINER) span = 23'(TrainerLen);
        else if (region == PH_PRG) span = 23'(prg_count) << PrgBankLog2;
        else span = 23'(chr_count) << ChrBankLog2;
        if ({1'b0, pos} + 23'd1 >= span) begin
          pos = '0;
          region = first_region(phase_e'(region + 1));
        end else begin
          pos = pos + 22'd1;
        end
      end
      PH_IGNORE: ;
      default: r.kind = PH_REJECT;
    endcase
    // Decoded fields reflect the state after this byte.
    r.header_valid = (error_state == ERR_NONE) && (region != PH_HEADER);
    r.error_code = error_state;
    if (r.header_valid) begin
      r.prg_banks = prg_count;
      r.chr_banks = chr_count;
      r.mirroring = {flags6[3], flags6[0]};
      r.battery = flags6[1];
      r.trainer = flags6[2];
      r.mapper = {flags7[7:4], flags6[7:4]};
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tagged_byte_t want;
    if (!rst_ni) begin
      region = PH_HEADER;
      pos = '0;
      magic_ok = 1'b1;
      prg_count = '0;
      chr_count = '0;
      flags6 = '0;
      flags7 = '0;
      error_state = ERR_NONE;
      tagged_q.delete();
      outstanding_o <= 0;
    end else begin
      // Results first: a result never belongs to a byte taken at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (tagged_q.size() == 0) begin
          $error("result with no byte pending: tuser %0d tdata %h", m_tuser_i, m_tdata_i);
          mismatches++;
        end else begin
          want = tagged_q.pop_front();
          check_field("kind", want.kind, m_tuser_i);
          check_field("data_byte", want.data_byte, m_tdata_i[7:0]);
          check_field("offset", want.offset, m_tdata_i[OffLsb +: 22]);
          check_field("header_valid", want.header_valid, m_tdata_i[HvBit]);
          check_field("error_code", want.error_code, m_tdata_i[ErrLsb +: 2]);
          check_field("prg_banks", want.prg_banks, m_tdata_i[PrgLsb +: 8]);
          check_field("chr_banks", want.chr_banks, m_tdata_i[ChrLsb +: 8]);
          check_field("mirroring", want.mirroring, m_tdata_i[MirLsb +: 2]);
          check_field("battery", want.battery, m_tdata_i[BatBit]);
          check_field("trainer", want.trainer, m_tdata_i[TrnBit]);
          check_field("mapper", want.mapper, m_tdata_i[MapLsb +: 8]);
        end
      end
      if (s_tvalid_i && s_tready_i) tagged_q.push_back(tag_byte(s_tdata_i));
      outstanding_o <= tagged_q.size();
    end
  end

endmodule

>>> tb/cartridge_image_header_loader_test.sv
`timescale 1ns / 100ps
// Testbench top for the cartridge image header loader: image stimulus, handshake idling, verdict.
module cartridge_image_header_loader_test;
  import cihl_pkg::*;

  localparam int ImageItems = 1450;   // rough size of one run's image
  localparam int MaxGap     = 11;     // longest idle stretch per request
  localparam int StallLimit = 2000;   // cycles without any transfer before giving up

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;     // [7:0] image_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;     // data_byte, offset, decoded header fields
  logic [2:0]  m_axis_tuser;     // [2:0] kind

  int mismatches;
  int outstanding;
  int idle_cycles;

  // Idle pacing: each side runs in stretches, each drawn as busy (random gaps)
  // or as back to back.
  int send_left = 0;
  bit send_busy;
  int recv_left = 0;
  bit recv_busy;

  cartridge_image_header_loader uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  cihl_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // One image byte per request. Valid stays high across back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (send_left == 0) begin
      send_busy = $urandom_range(0, 2) != 0;
      send_left = $urandom_range(16, 200);
    end
    send_left--;
    gap = send_busy ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] hdr [16];
    int pick;
    int k;
    int region_bytes;
    int body;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset happens once, so the whole run is one image. Its shape is drawn:
    //   0..9    corrupted magic (flag7 random, so the NES 2.0 mark may also be set)
    //   10..19  NES 2.0 mark with good magic
    //   20..44  arbitrary bank counts, image cut short
    //   45..99  no ROM banks, optional trainer, walked into the ignored tail
    for (int i = 0; i < 4; i++) hdr[i] = MagicBytes[i];
    hdr[6] = 8'($urandom);
    hdr[7] = 8'($urandom);
    // Padding bytes at both extremes.
    for (int i = 8; i < 16; i++) hdr[i] = i[0] ? 8'hFF : 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      k = $urandom_range(0, 3);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end else if (pick < 20) begin
      hdr[7][3:2] = 2'b10;
    end else if (hdr[7][3:2] == 2'b10) begin
      hdr[7][3:2] = 2'b11;
    end
    if (pick < 45) begin
      hdr[4] = 8'($urandom_range(0, 255));
      hdr[5] = 8'($urandom_range(0, 255));
    end else begin
      // even one bank is far longer than a run, so the tail needs empty ROM regions
      hdr[4] = 8'd0;
      hdr[5] = 8'd0;
    end
    region_bytes = (hdr[6][2] ? int'(TrainerLen) : 0) + int'(hdr[4]) * 16384
                   + int'(hdr[5]) * 8192;
    if (pick >= 45) begin
      body = region_bytes + ((ImageItems - 16 - region_bytes > 40) ?
                             ImageItems - 16 - region_bytes : 40);
    end else begin
      body = ImageItems - 16;
    end

    for (int i = 0; i < 16; i++) send_byte(hdr[i]);
    drain_results();

    for (int i = 0; i < body; i++) begin
      send_byte(8'($urandom));
      if ($urandom_range(0, 399) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random ready gaps, one draw per result.
  initial begin
    int gap;
    repeat (13) @(posedge clk_i);
    forever begin
      if (recv_left == 0) begin
        recv_busy = $urandom_range(0, 2) != 0;
        recv_left = $urandom_range(16, 200);
      end
      recv_left--;
      gap = recv_busy ? $urandom_range(0, MaxGap) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog: any accepted transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
src/cihl_pkg.sv
src/cartridge_image_header_loader.sv
src/cihl_checker.sv
tb/cihl_result_checker.sv
tb/cartridge_image_header_loader_test.sv
